// ===== rtl/bmp_24bit_stream_writer_defines.svh =====
// assertion macros for the bmp stream writer byte sequencer
`ifndef BMP_24BIT_STREAM_WRITER_DEFINES_SVH
`define BMP_24BIT_STREAM_WRITER_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define BMPW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define BMPW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/bmpw_pkg.sv =====
// types, constants and header byte lookup for the bmp stream writer
`timescale 1ns / 1ps
`default_nettype none

package bmpw_pkg;

    // configuration register file
    localparam int unsigned CFG_W = 13;
    localparam int unsigned IDX_W = 2;
    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // header layout
    localparam int unsigned HDR_IDX_W = 6;
    localparam logic [HDR_IDX_W-1:0] HDR_FIRST = 6'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = 6'd53;
    localparam logic [31:0] HDR_LEN   = 32'd54;
    localparam logic [31:0] INFO_SIZE = 32'd40;
    localparam logic [7:0]  BPP       = 8'd24;
    localparam logic [7:0]  PLANES    = 8'd1;
    localparam logic [7:0]  CHAR_B    = 8'h42;
    localparam logic [7:0]  CHAR_M    = 8'h4D;

    // command queue between front and back
    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned PTR_W     = (CMD_DEPTH < 2) ? 1 : $clog2(CMD_DEPTH);
    localparam int unsigned CNT_QW    = $clog2(CMD_DEPTH + 1);

    // one classified pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       hdr;
        logic [1:0] pad;
        logic       done;
    } t_cmd;

    // effective dimensions and image size
    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [31:0]      img;
    } t_dims;

    typedef enum logic [2:0] {
        PH_START,
        PH_HDR,
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_PAD
    } t_phase;

    // byte at a given offset of the 54-byte file header
    function automatic logic [7:0] hdr_byte(
        input logic [HDR_IDX_W-1:0] idx,
        input logic [CFG_W-1:0]     w,
        input logic [CFG_W-1:0]     h,
        input logic [31:0]          img
    );
        logic [31:0] file_size;
        logic [31:0] wide_w;
        logic [31:0] neg_h;
        logic [7:0]  b;
        file_size = img + HDR_LEN;
        wide_w    = 32'(w);
        neg_h     = 32'd0 - 32'(h);
        unique case (idx)
            6'd0:    b = CHAR_B;
            6'd1:    b = CHAR_M;
            6'd2:    b = file_size[7:0];
            6'd3:    b = file_size[15:8];
            6'd4:    b = file_size[23:16];
            6'd5:    b = file_size[31:24];
            6'd10:   b = HDR_LEN[7:0];
            6'd14:   b = INFO_SIZE[7:0];
            6'd18:   b = wide_w[7:0];
            6'd19:   b = wide_w[15:8];
            6'd20:   b = wide_w[23:16];
            6'd21:   b = wide_w[31:24];
            6'd22:   b = neg_h[7:0];
            6'd23:   b = neg_h[15:8];
            6'd24:   b = neg_h[23:16];
            6'd25:   b = neg_h[31:24];
            6'd26:   b = PLANES;
            6'd28:   b = BPP;
            6'd34:   b = img[7:0];
            6'd35:   b = img[15:8];
            6'd36:   b = img[23:16];
            6'd37:   b = img[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bmpw_cfg.sv =====
// configuration registers, dimension clamping and image size
`timescale 1ns / 1ps
`default_nettype none

module bmpw_cfg #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [bmpw_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [bmpw_pkg::CFG_W-1:0] i_cfg_data,
    output bmpw_pkg::t_dims             o_dims
);
    import bmpw_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [31:0]      r_img;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    logic [14:0]      row_bytes;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_IDX_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // zero counts as one, oversize counts as the maximum
    always_comb begin
        eff_w = r_width;
        if (r_width == '0) begin
            eff_w = CFG_W'(1);
        end else if (32'(r_width) > MAX_DIM) begin
            eff_w = CFG_W'(MAX_DIM);
        end
        eff_h = r_height;
        if (r_height == '0) begin
            eff_h = CFG_W'(1);
        end else if (32'(r_height) > MAX_DIM) begin
            eff_h = CFG_W'(MAX_DIM);
        end
    end

    // padded row length times rows, registered
    assign row_bytes = 15'(eff_w) * 15'd3 + 15'(eff_w[1:0]);

    always_ff @(posedge i_clk) begin
        r_img <= 32'(row_bytes * 28'(eff_h));
    end

    assign o_dims.width  = eff_w;
    assign o_dims.height = eff_h;
    assign o_dims.img    = r_img;

endmodule

`default_nettype wire

// ===== rtl/bmpw_front.sv =====
// pixel intake: column and row tracking, classification into commands
`timescale 1ns / 1ps
`default_nettype none

module bmpw_front #(
    parameter int CNT_W = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_blue,
    input  wire logic [7:0]      i_green,
    input  wire logic [7:0]      i_red,
    input  wire bmpw_pkg::t_dims i_dims,
    input  wire logic            i_q_full,
    output logic                 o_q_push,
    output bmpw_pkg::t_cmd       o_cmd
);
    import bmpw_pkg::*;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             row_last;
    logic             frame_last;

    assign o_q_push = i_push && !i_q_full;

    // end of row and end of frame tests
    assign row_last   = (14'(r_col) + 14'd1) >= 14'(i_dims.width);
    assign frame_last = row_last && ((14'(r_row) + 14'd1) >= 14'(i_dims.height));

    // next counter values
    always_comb begin
        n_col = r_col + CNT_W'(1);
        n_row = r_row;
        if (row_last) begin
            n_col = '0;
            n_row = frame_last ? '0 : r_row + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_q_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // command for the back end
    always_comb begin
        o_cmd.blue  = i_blue;
        o_cmd.green = i_green;
        o_cmd.red   = i_red;
        o_cmd.hdr   = (r_col == '0) && (r_row == '0);
        o_cmd.pad   = row_last ? i_dims.width[1:0] : 2'd0;
        o_cmd.done  = frame_last;
    end

endmodule

`default_nettype wire

// ===== rtl/bmpw_cmd_fifo.sv =====
// short command queue between intake and byte sequencer
`timescale 1ns / 1ps
`default_nettype none

module bmpw_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bmpw_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output bmpw_pkg::t_cmd      o_cmd
);
    import bmpw_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_QW'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmpw_back.sv =====
// byte sequencer: header, pixel bytes and row padding into the output register
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_24bit_stream_writer_defines.svh"

module bmpw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire bmpw_pkg::t_cmd  i_cmd,
    output logic                 o_q_pop,
    input  wire bmpw_pkg::t_dims i_dims,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_data_byte,
    output logic                 o_last_of_run,
    output logic                 o_frame_end
);
    import bmpw_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [HDR_IDX_W-1:0]  r_hdr_idx;
    logic [HDR_IDX_W-1:0]  n_hdr_idx;
    logic [1:0]            r_pad_cnt;
    logic [1:0]            n_pad_cnt;
    logic                  r_out_valid;
    logic [7:0]            r_out_data;
    logic                  r_out_last;
    logic                  r_out_end;
    logic                  step;
    logic [7:0]            byte_val;
    logic                  byte_last;

    // a byte moves when a command waits and the output slot frees up
    assign step = !i_q_empty && (!r_out_valid || i_pop);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_pad_cnt = r_pad_cnt;
        if (step) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_cmd.hdr) begin
                        n_phase   = PH_HDR;
                        n_hdr_idx = HDR_FIRST + HDR_IDX_W'(1);
                    end else begin
                        n_phase = PH_GREEN;
                    end
                end
                PH_HDR: begin
                    if (r_hdr_idx == HDR_LAST) begin
                        n_phase = PH_BLUE;
                    end else begin
                        n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                    end
                end
                PH_BLUE:  n_phase = PH_GREEN;
                PH_GREEN: n_phase = PH_RED;
                PH_RED: begin
                    if (i_cmd.pad == 2'd0) begin
                        n_phase = PH_START;
                    end else begin
                        n_phase   = PH_PAD;
                        n_pad_cnt = i_cmd.pad;
                    end
                end
                PH_PAD: begin
                    if (r_pad_cnt == 2'd1) begin
                        n_phase = PH_START;
                    end else begin
                        n_pad_cnt = r_pad_cnt - 2'd1;
                    end
                end
                default: n_phase = PH_START;
            endcase
        end
    end

    // byte selection for the current phase
    always_comb begin
        byte_val  = 8'd0;
        byte_last = 1'b0;
        unique case (r_phase)
            PH_START: begin
                byte_val = i_cmd.hdr
                    ? hdr_byte(HDR_FIRST, i_dims.width, i_dims.height, i_dims.img)
                    : i_cmd.blue;
            end
            PH_HDR:   byte_val = hdr_byte(r_hdr_idx, i_dims.width, i_dims.height, i_dims.img);
            PH_BLUE:  byte_val = i_cmd.blue;
            PH_GREEN: byte_val = i_cmd.green;
            PH_RED: begin
                byte_val  = i_cmd.red;
                byte_last = (i_cmd.pad == 2'd0);
            end
            PH_PAD: begin
                byte_val  = 8'd0;
                byte_last = (r_pad_cnt == 2'd1);
            end
            default: byte_val = 8'd0;
        endcase
    end

    assign o_q_pop = step && byte_last;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_hdr_idx <= HDR_FIRST;
            r_pad_cnt <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_pad_cnt <= n_pad_cnt;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= byte_val;
            r_out_last <= byte_last;
            r_out_end  <= byte_last && i_cmd.done;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_data_byte   = r_out_data;
    assign o_last_of_run = r_out_last;
    assign o_frame_end   = r_out_end;

    // checks
    `BMPW_ASSERT(a_end_is_last, i_clk, i_rst_n,
        (r_out_valid && r_out_end) |-> r_out_last, "frame end without last of run")
    `BMPW_ASSERT(a_hold_on_stall, i_clk, i_rst_n,
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_data)),
        "output byte changed while stalled")
    `BMPW_ASSERT_NEVER(a_hdr_idx_range, i_clk, i_rst_n,
        (r_phase == PH_HDR) && (r_hdr_idx > HDR_LAST), "header index past end")
    `BMPW_ASSERT_NEVER(a_pad_zero, i_clk, i_rst_n,
        (r_phase == PH_PAD) && (r_pad_cnt == 2'd0), "padding phase with no bytes left")

endmodule

`default_nettype wire

// ===== rtl/bmp_24bit_stream_writer.sv =====
// top level of the 24-bit top-down bmp byte stream writer
//
//  channel   direction  handshake               payload
//  pixel     in         push / full             i_blue, i_green, i_red
//  bytes     out        empty / pop             o_data_byte, o_last_of_run, o_frame_end
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  one byte per cycle from a single output register unless pop stalls or the queue is empty;
//  a pixel is 3 bytes, plus 54 header bytes first in a frame and 0 to 3 padding at row end
//  a two-entry command queue lets pixels be taken while earlier bytes still drain
//  synchronous active-low reset clears counters, queue and sequencer; no clearing pass
//  a stalled pop holds the byte; a full queue raises full until the sequencer frees an entry
`timescale 1ns / 1ps
`default_nettype none

module bmp_24bit_stream_writer #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 i_blue,
    input  wire logic [7:0]                 i_green,
    input  wire logic [7:0]                 i_red,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      o_data_byte,
    output logic                            o_last_of_run,
    output logic                            o_frame_end,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bmpw_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [bmpw_pkg::CFG_W-1:0] i_cfg_data
);
    import bmpw_pkg::*;

    // counter width follows MAX_DIM, capped at the 13-bit register width
    localparam int CNT_W = (MAX_DIM > 8191) ? 13 : ((MAX_DIM < 2) ? 1 : $clog2(MAX_DIM));

    t_dims dims;
    t_cmd  fr_cmd;
    t_cmd  q_cmd;
    logic  fr_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    assign full = q_full;

    // configuration
    bmpw_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dims      (dims)
    );

    // pixel intake
    bmpw_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_blue   (i_blue),
        .i_green  (i_green),
        .i_red    (i_red),
        .i_dims   (dims),
        .i_q_full (q_full),
        .o_q_push (fr_push),
        .o_cmd    (fr_cmd)
    );

    // command queue
    bmpw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // byte sequencer
    bmpw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (q_cmd),
        .o_q_pop       (q_pop),
        .i_dims        (dims),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_data_byte   (o_data_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for the bmp 24-bit stream writer: directed rows, then random frames
`timescale 1ns / 1ps
module tb;
    import bmpw_pkg::*;

    localparam int unsigned MAX_DIM        = 4096;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned SEGMENTS       = 12;
    localparam int unsigned SEG_PIXELS     = 12;
    localparam int unsigned PRESSURE_SEG   = 4;
    localparam int unsigned N_DIRECTED     = 25;

    // indexes the block has no register behind
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam logic [CFG_W-1:0] CFG_ALL_ONES    = 13'h1fff;
    localparam logic [CFG_W-1:0] CFG_MAX_DIM     = 13'd4096;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        bit               chk;
        int               exp_n;
        bit               exp_fend;
    } t_stim_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } t_file_byte;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [7:0]       i_blue;
    logic [7:0]       i_green;
    logic [7:0]       i_red;
    logic             empty;
    logic             pop;
    logic [7:0]       o_data_byte;
    logic             o_last_of_run;
    logic             o_frame_end;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    // typed expectation riding along with the pixel on the input
    logic             typed_chk;
    int               typed_n;
    logic             typed_fend;

    // mirror of the block: registers and raster position
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    t_file_byte       pending_bytes[$];

    int               fault_count;
    int unsigned      idle_cycles;
    int unsigned      push_idle_pct;
    int unsigned      pop_stall_pct;
    bit               hold_request;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // first pixel after reset carries the header for 640 x 480
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'hff, 8'h00, 8'hff, 1, 57, 0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h00, 8'hff, 8'h00, 1, 3,  0},
        // shrink mid-frame: the next pixel closes row and frame
        '{ROW_CONFIG, CFG_IDX_WIDTH,   13'd1,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_HEIGHT,  13'd1,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h12, 8'h34, 8'h56, 1, 4,  1},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'hff, 8'hff, 8'hff, 1, 58, 1},
        // zero dimensions count as one
        '{ROW_CONFIG, CFG_IDX_WIDTH,   13'd0,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_HEIGHT,  13'd0,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h00, 8'h00, 8'h00, 1, 58, 1},
        // oversized dimensions clamp to the maximum
        '{ROW_CONFIG, CFG_IDX_WIDTH,   CFG_ALL_ONES, 8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_HEIGHT,  CFG_ALL_ONES, 8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'ha5, 8'h5a, 8'hc3, 1, 57, 0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h3c, 8'hc3, 8'h96, 1, 3,  0},
        '{ROW_CONFIG, CFG_IDX_WIDTH,   CFG_MAX_DIM,  8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_HEIGHT,  13'd1,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h69, 8'h96, 8'h0f, 0, 0,  0},
        // writes to unused indexes change nothing
        '{ROW_CONFIG, CFG_IDX_SPARE_A, CFG_ALL_ONES, 8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_SPARE_B, 13'd0,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        // width below the current column, then a full 3 x 2 row with padding
        '{ROW_CONFIG, CFG_IDX_WIDTH,   13'd3,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_CONFIG, CFG_IDX_HEIGHT,  13'd2,        8'h00, 8'h00, 8'h00, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h80, 8'h7f, 8'h01, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'hfe, 8'h01, 8'h80, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h55, 8'haa, 8'h55, 0, 0,  0},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'haa, 8'h55, 8'haa, 1, 6,  1},
        '{ROW_PIXEL,  CFG_IDX_WIDTH,   13'd0,        8'h01, 8'h02, 8'h04, 1, 57, 0}
    };

    bmp_24bit_stream_writer #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_last_of_run(o_last_of_run),
        .o_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register value as the block uses it
    function automatic logic [31:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return 32'd1;
        if (32'(v) > MAX_DIM) return MAX_DIM;
        return 32'(v);
    endfunction

    // bytes of the file stream caused by one pixel, queued in order
    function automatic void bmp_bytes_for_pixel(
        input  logic [7:0] b,
        input  logic [7:0] g,
        input  logic [7:0] r,
        output int         n,
        output bit         ends_frame
    );
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] pad;
        logic [31:0] img;
        logic [31:0] fsize;
        logic [31:0] neg_h;
        logic [31:0] hdr_len_w;
        logic [31:0] info_w;
        logic [7:0]  hd [54];
        logic [7:0]  seq [60];
        t_file_byte  fb;
        w          = eff_dim(width_reg);
        h          = eff_dim(height_reg);
        pad        = w & 32'd3;
        img        = (w * 32'd3 + pad) * h;
        fsize      = img + HDR_LEN;
        neg_h      = 32'd0 - h;
        hdr_len_w  = HDR_LEN;
        info_w     = INFO_SIZE;
        n          = 0;
        ends_frame = 1'b0;
        // header only on the first pixel of a frame
        if (col_pos == 0 && row_pos == 0) begin
            for (int k = 0; k < 54; k++) hd[k] = 8'd0;
            hd[0]  = CHAR_B;
            hd[1]  = CHAR_M;
            hd[26] = PLANES;
            hd[28] = BPP;
            for (int k = 0; k < 4; k++) begin
                hd[2 + k]  = fsize[8*k +: 8];
                hd[10 + k] = hdr_len_w[8*k +: 8];
                hd[14 + k] = info_w[8*k +: 8];
                hd[18 + k] = w[8*k +: 8];
                hd[22 + k] = neg_h[8*k +: 8];
                hd[34 + k] = img[8*k +: 8];
            end
            for (int k = 0; k < 54; k++) begin
                seq[n] = hd[k];
                n      = n + 1;
            end
        end
        seq[n]     = b;
        seq[n + 1] = g;
        seq[n + 2] = r;
        n          = n + 3;
        // row end pads the row to a multiple of four bytes and may close the frame
        if (col_pos + 1 >= w) begin
            for (int k = 0; k < int'(pad); k++) begin
                seq[n] = 8'd0;
                n      = n + 1;
            end
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos    = 0;
                ends_frame = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        for (int k = 0; k < n; k++) begin
            fb.data = seq[k];
            fb.last = (k == n - 1);
            fb.fend = ends_frame && (k == n - 1);
            pending_bytes.push_back(fb);
        end
    endfunction

    // prediction on every pixel transfer, comparison on every byte transfer
    always @(posedge i_clk) begin : scoreboard
        int         n_bytes;
        bit         ends_frame;
        t_file_byte want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            pending_bytes.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == CFG_IDX_HEIGHT) height_reg = i_cfg_data;
            end
            if (push && !full) begin
                bmp_bytes_for_pixel(i_blue, i_green, i_red, n_bytes, ends_frame);
                if (typed_chk && n_bytes != typed_n) begin
                    $error("byte_count: expected %0d, actual %0d", typed_n, n_bytes);
                    fault_count++;
                end
                if (typed_chk && ends_frame != typed_fend) begin
                    $error("frame_close: expected %0b, actual %0b", typed_fend, ends_frame);
                    fault_count++;
                end
            end
            if (pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected byte %0h with nothing pending", o_data_byte);
                    fault_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_data_byte !== want.data) begin
                        $error("data_byte: expected %0h, actual %0h", want.data, o_data_byte);
                        fault_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, o_last_of_run);
                        fault_count++;
                    end
                    if (o_frame_end !== want.fend) begin
                        $error("frame_end: expected %0b, actual %0b", want.fend, o_frame_end);
                        fault_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bmp_24bit_stream_writer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // byte receiver: random stalls, one long hold-off on request
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // offer one pixel, with a random idle stretch ahead of it
    task automatic offer_pixel(
        input logic [7:0] b,
        input logic [7:0] g,
        input logic [7:0] r,
        input bit         chk,
        input int         n,
        input bit         fend
    );
        if (push_idle_pct != 0 && $urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < push_idle_pct);
        end
        push       <= 1'b1;
        i_blue     <= b;
        i_green    <= g;
        i_red      <= r;
        typed_chk  <= chk;
        typed_n    <= n;
        typed_fend <= fend;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // stop offering and let every pending byte leave the block
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly small frames so that rows and frames close often
    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned small_max);
        if ($urandom_range(7) == 0) return CFG_W'($urandom_range(8191));
        return CFG_W'($urandom_range(small_max, 1));
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_blue        = 8'd0;
        i_green       = 8'd0;
        i_red         = 8'd0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        typed_chk     = 1'b0;
        typed_n       = 0;
        typed_fend    = 1'b0;
        fault_count   = 0;
        idle_cycles   = 0;
        push_idle_pct = 0;
        pop_stall_pct = 0;
        hold_request  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CONFIG) begin
                wait_drained();
                write_register(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                offer_pixel(directed_rows[k].blue, directed_rows[k].green,
                            directed_rows[k].red, directed_rows[k].chk,
                            directed_rows[k].exp_n, directed_rows[k].exp_fend);
            end
        end

        // random segments, each with new dimensions and its own idling mix
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            write_register(CFG_IDX_WIDTH, pick_dim(6));
            write_register(CFG_IDX_HEIGHT, pick_dim(3));
            case (seg % 4)
                0: begin
                    push_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1: begin
                    push_idle_pct = 78;
                    pop_stall_pct = 0;
                end
                2: begin
                    push_idle_pct = 0;
                    pop_stall_pct = 78;
                end
                default: begin
                    push_idle_pct = 17;
                    pop_stall_pct = 17;
                end
            endcase
            // receiver holds off while pixels keep coming
            if (seg == PRESSURE_SEG) hold_request = 1'b1;
            repeat (SEG_PIXELS) begin
                offer_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 1'b0, 0, 1'b0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_bytes.size() == 0) begin
            $display("bmp_24bit_stream_writer verification clean");
        end else begin
            $display("bmp_24bit_stream_writer verification failed");
        end
        $finish;
    end

endmodule
